// ===== src/vvff_pkg.sv =====
// vvff_pkg: shared types, grid constants and address helpers for the visible face finder
// no dependencies; imported by every module of the block
package vvff_pkg;

	localparam int SIZE_X    = 32;
	localparam int SIZE_Y    = 32;
	localparam int SIZE_Z    = 32;
	localparam int KIND_BITS = 4;

	localparam int COORD_W   = 5;
	localparam int KIND_W    = 4;
	localparam int SIDE_W    = 3;
	localparam int NB_W      = COORD_W + 1;
	localparam int MEM_DEPTH = SIZE_X * SIZE_Y * SIZE_Z;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	localparam logic [SIDE_W-1:0] SIDE_BACK   = 3'd0;
	localparam logic [SIDE_W-1:0] SIDE_FRONT  = 3'd1;
	localparam logic [SIDE_W-1:0] SIDE_LEFT   = 3'd2;
	localparam logic [SIDE_W-1:0] SIDE_RIGHT  = 3'd3;
	localparam logic [SIDE_W-1:0] SIDE_BOTTOM = 3'd4;
	localparam logic [SIDE_W-1:0] SIDE_TOP    = 3'd5;

	typedef struct packed {
		logic               req_type;
		logic [COORD_W-1:0] cell_x;
		logic [COORD_W-1:0] cell_y;
		logic [COORD_W-1:0] cell_z;
		logic [KIND_W-1:0]  new_kind;
	} item_t;

	typedef struct packed {
		logic [COORD_W-1:0] face_x;
		logic [COORD_W-1:0] face_y;
		logic [COORD_W-1:0] face_z;
		logic [SIDE_W-1:0]  face_side;
		logic [KIND_W-1:0]  face_kind;
		logic               see_through;
		logic               face_valid;
		logic               last_face;
	} result_t;

	// classified command passed from front to back
	typedef struct packed {
		logic                 is_query;
		logic                 in_grid;
		logic [COORD_W-1:0]   x;
		logic [COORD_W-1:0]   y;
		logic [COORD_W-1:0]   z;
		logic [KIND_BITS-1:0] kind;
	} cmd_t;

	typedef struct packed {
		logic              in_grid;
		logic [ADDR_W-1:0] addr;
	} nb_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SELF,
		ST_SIDE,
		ST_DONE
	} back_state_t;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [NB_W-1:0] x,
		input logic [NB_W-1:0] y, input logic [NB_W-1:0] z);
		return ADDR_W'(int'(y) * (SIZE_Z * SIZE_X) + int'(z) * SIZE_X + int'(x));
	endfunction

	function automatic logic coord_in_grid(input logic [COORD_W-1:0] x,
		input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z);
		return (int'(x) < SIZE_X) && (int'(y) < SIZE_Y) && (int'(z) < SIZE_Z);
	endfunction

	// neighbour of an in-grid cell on one side
	function automatic nb_t neighbour(input logic [COORD_W-1:0] x,
		input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z,
		input logic [SIDE_W-1:0] side);
		logic [NB_W-1:0] nx;
		logic [NB_W-1:0] ny;
		logic [NB_W-1:0] nz;
		nb_t             r;
		nx = NB_W'(x);
		ny = NB_W'(y);
		nz = NB_W'(z);
		r.in_grid = 1'b0;
		case (side)
			SIDE_BACK: begin
				r.in_grid = (z != '0);
				nz = nz - NB_W'(1);
			end
			SIDE_FRONT: begin
				nz = nz + NB_W'(1);
				r.in_grid = int'(nz) < SIZE_Z;
			end
			SIDE_LEFT: begin
				r.in_grid = (x != '0);
				nx = nx - NB_W'(1);
			end
			SIDE_RIGHT: begin
				nx = nx + NB_W'(1);
				r.in_grid = int'(nx) < SIZE_X;
			end
			SIDE_BOTTOM: begin
				r.in_grid = (y != '0);
				ny = ny - NB_W'(1);
			end
			SIDE_TOP: begin
				ny = ny + NB_W'(1);
				r.in_grid = int'(ny) < SIZE_Y;
			end
			default: r.in_grid = 1'b0;
		endcase
		r.addr = cell_addr(nx, ny, nz);
		return r;
	endfunction

endpackage

// ===== src/vvff_front.sv =====
// vvff_front: accepts input words, classifies them and queues commands for the back end
// depends on vvff_pkg
module vvff_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	input  vvff_pkg::item_t item,
	input  logic            clearing,
	output logic            cmd_valid,
	input  logic            cmd_ready,
	output vvff_pkg::cmd_t  cmd
);
	import vvff_pkg::*;

	cmd_t       fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	cmd_t       cls;
	logic       push;
	logic       pop;

	always_comb begin
		cls.is_query = (item.req_type == REQ_QUERY);
		cls.in_grid  = coord_in_grid(item.cell_x, item.cell_y, item.cell_z);
		cls.x        = item.cell_x;
		cls.y        = item.cell_y;
		cls.z        = item.cell_z;
		cls.kind     = KIND_BITS'(item.new_kind);
	end

	assign item_ready = !clearing && (cnt_q != 2'd2);
	// writes outside the grid are taken and dropped here
	assign push       = item_valid && item_ready && (cls.is_query || cls.in_grid);
	assign cmd_valid  = (cnt_q != 2'd0);
	assign pop        = cmd_valid && cmd_ready;
	assign cmd        = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== src/vvff_back.sv =====
// vvff_back: grid memory, query sequencer, transparent type register and output register
// depends on vvff_pkg
module vvff_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  vvff_pkg::cmd_t    cmd,
	output logic              clearing,
	input  logic              cfg_we,
	input  logic [3:0]        cfg_wdata,
	output logic              res_valid,
	input  logic              res_ready,
	output vvff_pkg::result_t res
);
	import vvff_pkg::*;

	logic [KIND_BITS-1:0] mem [MEM_DEPTH];
	logic [KIND_BITS-1:0] rdata_q;

	back_state_t          state_q, state_d;
	logic [ADDR_W-1:0]    clr_q, clr_d;
	cmd_t                 cur_q;
	logic                 cur_load;
	logic [KIND_BITS-1:0] kind_q, kind_d;
	logic [SIDE_W-1:0]    side_q, side_d;
	logic                 nb_in_q, nb_in_d;
	logic                 pend_valid_q, pend_valid_d;
	logic [SIDE_W-1:0]    pend_side_q, pend_side_d;
	logic [KIND_W-1:0]    trans_q;

	logic                 mem_we;
	logic [ADDR_W-1:0]    mem_wa;
	logic [KIND_BITS-1:0] mem_wd;
	logic                 mem_re;
	logic [ADDR_W-1:0]    mem_ra;

	logic                 res_valid_q;
	result_t              res_q;
	logic                 emit;
	result_t              emit_res;
	logic                 can_emit;

	logic [KIND_BITS-1:0] self_kind;
	logic                 visible;
	logic                 see;
	nb_t                  nb_first;
	nb_t                  nb_next;

	assign clearing  = (state_q == ST_CLEAR);
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign can_emit  = !res_valid_q || res_ready;

	assign self_kind = cur_q.in_grid ? rdata_q : '0;
	assign visible   = !nb_in_q || (rdata_q == '0);
	assign see       = (trans_q != '0) && (KIND_W'(kind_q) == trans_q);
	assign nb_first  = neighbour(cur_q.x, cur_q.y, cur_q.z, SIDE_BACK);
	assign nb_next   = neighbour(cur_q.x, cur_q.y, cur_q.z, side_q + SIDE_W'(1));

	always_comb begin
		state_d      = state_q;
		clr_d        = clr_q;
		cur_load     = 1'b0;
		kind_d       = kind_q;
		side_d       = side_q;
		nb_in_d      = nb_in_q;
		pend_valid_d = pend_valid_q;
		pend_side_d  = pend_side_q;
		cmd_ready    = 1'b0;
		mem_we       = 1'b0;
		mem_wa       = cell_addr(NB_W'(cmd.x), NB_W'(cmd.y), NB_W'(cmd.z));
		mem_wd       = cmd.kind;
		mem_re       = 1'b0;
		mem_ra       = mem_wa;
		emit         = 1'b0;

		emit_res.face_x      = cur_q.x;
		emit_res.face_y      = cur_q.y;
		emit_res.face_z      = cur_q.z;
		emit_res.face_side   = pend_side_q;
		emit_res.face_kind   = KIND_W'(kind_q);
		emit_res.see_through = see;
		emit_res.face_valid  = 1'b1;
		emit_res.last_face   = 1'b0;

		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				mem_wd = '0;
				clr_d  = clr_q + ADDR_W'(1);
				if (clr_q == ADDR_W'(MEM_DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_ready = 1'b1;
					if (!cmd.is_query) begin
						mem_we = 1'b1;
					end else begin
						cur_load = 1'b1;
						mem_re   = cmd.in_grid;
						state_d  = ST_SELF;
					end
				end
			end
			ST_SELF: begin
				kind_d       = self_kind;
				pend_valid_d = 1'b0;
				if (self_kind == '0) begin
					state_d = ST_DONE;
				end else begin
					mem_re  = nb_first.in_grid;
					mem_ra  = nb_first.addr;
					nb_in_d = nb_first.in_grid;
					side_d  = SIDE_BACK;
					state_d = ST_SIDE;
				end
			end
			ST_SIDE: begin
				// a new face pushes the held one out; hold the read if the output is full
				if (!(visible && pend_valid_q && !can_emit)) begin
					if (visible) begin
						emit         = pend_valid_q;
						pend_valid_d = 1'b1;
						pend_side_d  = side_q;
					end
					if (side_q == SIDE_TOP) begin
						state_d = ST_DONE;
					end else begin
						mem_re  = nb_next.in_grid;
						mem_ra  = nb_next.addr;
						nb_in_d = nb_next.in_grid;
						side_d  = side_q + SIDE_W'(1);
					end
				end
			end
			ST_DONE: begin
				emit_res.last_face = 1'b1;
				if (!pend_valid_q) begin
					emit_res.face_side   = SIDE_BACK;
					emit_res.see_through = 1'b0;
					emit_res.face_valid  = 1'b0;
				end
				if (can_emit) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (cur_load) begin
			cur_q <= cmd;
		end
		if (emit) begin
			res_q <= emit_res;
		end
		kind_q      <= kind_d;
		side_q      <= side_d;
		nb_in_q     <= nb_in_d;
		pend_side_q <= pend_side_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			pend_valid_q <= 1'b0;
			res_valid_q  <= 1'b0;
			trans_q      <= '0;
		end else begin
			state_q      <= state_d;
			clr_q        <= clr_d;
			pend_valid_q <= pend_valid_d;
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				trans_q <= cfg_wdata;
			end
		end
	end

endmodule

// ===== src/voxel_visible_face_finder.sv =====
// voxel_visible_face_finder: top level, front end and queue feeding the grid back end
// depends on vvff_pkg, vvff_front, vvff_back
// a query reads its own cell, then checks its six neighbours in turn, all on one memory port; the back
// end takes no new command until it has handed the query's last word to the output register, while
// the front queue can hold up to two more words; a write goes straight to the grid memory
// output stalls hold a query back while the output register stays full
// reset: the grid is cleared one cell a cycle, all 32768 cells, during which no word is taken
module voxel_visible_face_finder (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  vvff_pkg::item_t   item,
	output logic              res_valid,
	input  logic              res_ready,
	output vvff_pkg::result_t res,
	input  logic              cfg_we,
	input  logic [3:0]        cfg_wdata
);
	import vvff_pkg::*;

	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;
	logic clearing;

	vvff_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.clearing   (clearing),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd)
	);

	vvff_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd),
		.clearing   (clearing),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

endmodule

// ===== tb/voxel_visible_face_finder_tb.sv =====
`timescale 1ns / 1ps
// voxel_visible_face_finder_tb: self-checking bench for the visible face finder
// keeps its own copy of the block grid and predicts every face word; needs vvff_pkg and the rtl
module voxel_visible_face_finder_tb;
	import vvff_pkg::*;

	localparam int WATCHDOG_LIMIT = 150000;
	localparam int SETTLE_CYCLES  = 64;
	localparam int HOLD_CYCLES    = 300;
	localparam int MAX_REPORTS    = 10;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       item_valid = 1'b0;
	logic       item_ready;
	item_t      item       = '0;
	logic       res_valid;
	logic       res_ready  = 1'b0;
	result_t    res;
	logic       cfg_we     = 1'b0;
	logic [3:0] cfg_wdata  = '0;

	logic [KIND_W-1:0] grid_kinds [MEM_DEPTH];
	logic [KIND_W-1:0] clear_kind   = '0;   // transparent type as the block holds it
	result_t           face_q [$];
	int                mismatches   = 0;
	int                idle_pct     = 10;
	logic              hold_go      = 1'b0;
	int                hold_left    = 0;
	int                quiet_cycles = 0;

	voxel_visible_face_finder i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [KIND_W-1:0] kind_at(input int x, input int y, input int z);
		// outside the grid counts as empty
		if (x < 0 || x >= SIZE_X || y < 0 || y >= SIZE_Y || z < 0 || z >= SIZE_Z)
			return '0;
		return grid_kinds[y * SIZE_Z * SIZE_X + z * SIZE_X + x];
	endfunction

	function automatic void predict_faces(input item_t w);
		int                x;
		int                y;
		int                z;
		int                nx;
		int                ny;
		int                nz;
		int                s;
		int                n;
		logic [KIND_W-1:0] kind;
		result_t           held;
		x = int'(w.cell_x);
		y = int'(w.cell_y);
		z = int'(w.cell_z);
		if (w.req_type == REQ_WRITE) begin
			if (x < SIZE_X && y < SIZE_Y && z < SIZE_Z)
				grid_kinds[y * SIZE_Z * SIZE_X + z * SIZE_X + x] =
					w.new_kind & KIND_W'((1 << KIND_BITS) - 1);
			return;
		end
		kind = kind_at(x, y, z);
		held.face_x      = w.cell_x;
		held.face_y      = w.cell_y;
		held.face_z      = w.cell_z;
		held.face_side   = SIDE_BACK;
		held.face_kind   = kind;
		held.see_through = (clear_kind != '0) && (kind == clear_kind);
		held.face_valid  = 1'b1;
		held.last_face   = 1'b0;
		n = 0;
		if (kind != '0) begin
			for (s = int'(SIDE_BACK); s <= int'(SIDE_TOP); s++) begin
				nx = x;
				ny = y;
				nz = z;
				case (SIDE_W'(s))
					SIDE_BACK:   nz = z - 1;
					SIDE_FRONT:  nz = z + 1;
					SIDE_LEFT:   nx = x - 1;
					SIDE_RIGHT:  nx = x + 1;
					SIDE_BOTTOM: ny = y - 1;
					default:     ny = y + 1;
				endcase
				if (kind_at(nx, ny, nz) == '0) begin
					// push the previous face only now, so the final one can carry last
					if (n != 0)
						face_q = {face_q, held};
					held.face_side = SIDE_W'(s);
					n++;
				end
			end
		end
		if (n == 0) begin
			held.face_side   = SIDE_BACK;
			held.see_through = 1'b0;
			held.face_valid  = 1'b0;
		end
		held.last_face = 1'b1;
		face_q = {face_q, held};
	endfunction

	function automatic void note_mismatch(input string what, input result_t want,
		input result_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("mismatch (%s) at %0t: expected x=%0d y=%0d z=%0d side=%0d kind=%0d",
				what, $realtime, want.face_x, want.face_y, want.face_z, want.face_side,
				want.face_kind);
			$display("  expected see=%b valid=%b last=%b", want.see_through,
				want.face_valid, want.last_face);
			$display("  got      x=%0d y=%0d z=%0d side=%0d kind=%0d see=%b valid=%b last=%b",
				got.face_x, got.face_y, got.face_z, got.face_side, got.face_kind,
				got.see_through, got.face_valid, got.last_face);
		end
	endfunction

	// check the outgoing word first, then predict from the incoming one
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (res_valid && res_ready) begin
				if (face_q.size() == 0) begin
					note_mismatch("no word expected", '0, res);
				end else begin
					want = face_q.pop_front();
					if (res.face_x !== want.face_x || res.face_y !== want.face_y ||
						res.face_z !== want.face_z || res.face_side !== want.face_side ||
						res.face_kind !== want.face_kind ||
						res.see_through !== want.see_through ||
						res.face_valid !== want.face_valid ||
						res.last_face !== want.last_face)
						note_mismatch("face word", want, res);
				end
			end
			if (cfg_we)
				clear_kind = cfg_wdata;
			if (item_valid && item_ready)
				predict_faces(item);
		end
	end

	// receiver: random stalls, or a long hold-off on request
	always @(posedge clk) begin
		if (hold_go) begin
			hold_left <= HOLD_CYCLES;
			res_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			res_ready <= 1'b0;
		end else begin
			res_ready <= ($urandom_range(99) >= idle_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (res_valid && res_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic item_t make_word(input logic req, input int x, input int y, input int z,
		input logic [3:0] kind);
		item_t w;
		w.req_type = req;
		w.cell_x   = COORD_W'(x);
		w.cell_y   = COORD_W'(y);
		w.cell_z   = COORD_W'(z);
		w.new_kind = kind;
		return w;
	endfunction

	function automatic logic [3:0] pick_kind();
		int r;
		r = $urandom_range(99);
		if (r < 25)
			return '0;
		if (r < 50 && clear_kind != '0)
			return clear_kind;
		return 4'($urandom_range(15, 1));
	endfunction

	function automatic int pick_origin();
		case ($urandom_range(2))
			0:       return 0;
			1:       return 28;
			default: return $urandom_range(28);
		endcase
	endfunction

	task automatic send_word(input item_t w);
		while ($urandom_range(99) < idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= w;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
	endtask

	task automatic wait_faces_drained();
		item_valid <= 1'b0;
		@(posedge clk);
		while (face_q.size() != 0)
			@(posedge clk);
		// writes give no word, so leave time for any still in flight
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_transparent(input logic [3:0] kind);
		cfg_we    <= 1'b1;
		cfg_wdata <= kind;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// builds in a 4x4x4 window and queries inside it, with some stray words
	task automatic send_cluster(input int n_items);
		int ox;
		int oy;
		int oz;
		int r;
		int i;
		ox = pick_origin();
		oy = pick_origin();
		oz = pick_origin();
		for (i = 0; i < n_items; i++) begin
			r = $urandom_range(99);
			if (i < 12 || r < 40)
				send_word(make_word(REQ_WRITE, ox + $urandom_range(3), oy + $urandom_range(3),
					oz + $urandom_range(3), pick_kind()));
			else if (r < 90)
				send_word(make_word(REQ_QUERY, ox + $urandom_range(3), oy + $urandom_range(3),
					oz + $urandom_range(3), 4'($urandom)));
			else
				send_word(make_word(1'($urandom), $urandom_range(31), $urandom_range(31),
					$urandom_range(31), 4'($urandom)));
		end
	endtask

	task automatic test_empty_grid();
		send_word(make_word(REQ_QUERY, 0, 0, 0, 4'd15));
		send_word(make_word(REQ_QUERY, 31, 31, 31, 4'd0));
		send_word(make_word(REQ_QUERY, 17, 5, 22, 4'd9));
	endtask

	task automatic test_lone_and_buried_blocks();
		wait_faces_drained();
		set_transparent(4'd15);
		// lone blocks in opposite corners show all six sides
		send_word(make_word(REQ_WRITE, 0, 0, 0, 4'd15));
		send_word(make_word(REQ_QUERY, 0, 0, 0, 4'd0));
		send_word(make_word(REQ_WRITE, 31, 31, 31, 4'd1));
		send_word(make_word(REQ_QUERY, 31, 31, 31, 4'd15));
		// fully buried block shows nothing
		send_word(make_word(REQ_WRITE, 10, 10, 10, 4'd5));
		send_word(make_word(REQ_WRITE, 10, 10, 9, 4'd7));
		send_word(make_word(REQ_WRITE, 10, 10, 11, 4'd7));
		send_word(make_word(REQ_WRITE, 9, 10, 10, 4'd7));
		send_word(make_word(REQ_WRITE, 11, 10, 10, 4'd7));
		send_word(make_word(REQ_WRITE, 10, 9, 10, 4'd7));
		send_word(make_word(REQ_WRITE, 10, 11, 10, 4'd7));
		send_word(make_word(REQ_QUERY, 10, 10, 10, 4'd0));
		send_word(make_word(REQ_QUERY, 10, 10, 9, 4'd0));
		// open the front side only
		send_word(make_word(REQ_WRITE, 10, 10, 11, 4'd0));
		send_word(make_word(REQ_QUERY, 10, 10, 10, 4'd0));
		// erased block reads back as empty
		send_word(make_word(REQ_WRITE, 0, 0, 0, 4'd0));
		send_word(make_word(REQ_QUERY, 0, 0, 0, 4'd0));
		send_word(make_word(REQ_WRITE, 30, 1, 31, 4'd10));
		send_word(make_word(REQ_QUERY, 30, 1, 31, 4'd6));
	endtask

	task automatic test_random_clusters();
		int         p;
		logic [3:0] t;
		for (p = 0; p < 5; p++) begin
			case (p)
				0:       t = 4'd0;
				1:       t = 4'd15;
				2:       t = 4'd1;
				default: t = 4'($urandom_range(14, 2));
			endcase
			wait_faces_drained();
			set_transparent(t);
			send_cluster(50);
		end
	endtask

	task automatic test_output_backpressure();
		int ox;
		int oy;
		int oz;
		int i;
		wait_faces_drained();
		set_transparent(4'($urandom_range(15)));
		ox = pick_origin();
		oy = pick_origin();
		oz = pick_origin();
		for (i = 0; i < 8; i++)
			send_word(make_word(REQ_WRITE, ox + $urandom_range(1), oy + $urandom_range(1),
				oz + $urandom_range(1), 4'($urandom_range(15, 1))));
		item_valid <= 1'b0;
		hold_go    <= 1'b1;
		@(posedge clk);
		hold_go    <= 1'b0;
		// keep offering queries while the output is held so the block backs up
		for (i = 0; i < 24; i++)
			send_word(make_word(REQ_QUERY, ox + $urandom_range(2), oy + $urandom_range(2),
				oz + $urandom_range(2), 4'($urandom)));
		wait_faces_drained();
	endtask

	task automatic test_back_to_back();
		idle_pct <= 0;
		wait_faces_drained();
		send_cluster(40);
		idle_pct <= 10;
	endtask

	initial begin
		foreach (grid_kinds[i])
			grid_kinds[i] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		test_empty_grid();
		test_lone_and_buried_blocks();
		test_random_clusters();
		test_output_backpressure();
		test_back_to_back();
		wait_faces_drained();
		if (mismatches == 0 && face_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
src/vvff_pkg.sv
src/vvff_front.sv
src/vvff_back.sv
src/voxel_visible_face_finder.sv
tb/voxel_visible_face_finder_tb.sv
